// ----- rtl/dlpa_pkg.sv -----
// dlpa_pkg: shared types, codes and helpers of the display-list primitive assembler
// no dependencies; used by the configuration interface and every rtl module
`default_nettype none

package dlpa_pkg;

  // defaults for top-level parameters
  localparam int TEXCOORD_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int TEXCOORD_MAX       = 8;

  // batch opcodes
  localparam logic [7:0] OP_STRIP = 8'h98;
  localparam logic [7:0] OP_LIST  = 8'hA0;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_MATRIX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_TEX_MATRIX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_COLOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXCOORD_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONVERT        = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ATTR    = 2'd0;
  localparam logic [1:0] KIND_TRI     = 2'd1;
  localparam logic [1:0] KIND_BATCH   = 2'd2;
  localparam logic [1:0] KIND_STOPPED = 2'd3;

  // attribute slots
  localparam logic [3:0] SLOT_MATRIX   = 4'd0;
  localparam logic [3:0] SLOT_TEXMTX   = 4'd1;
  localparam logic [3:0] SLOT_POSITION = 4'd2;
  localparam logic [3:0] SLOT_NORMAL   = 4'd3;
  localparam logic [3:0] SLOT_COLOR    = 4'd4;
  localparam logic [3:0] SLOT_TEX0     = 4'd5;
  localparam logic [3:0] SLOT_PAD      = 4'd13;
  localparam logic [3:0] SLOT_END      = 4'd14;
  localparam int         NUM_SLOTS     = 14;

  // decoder phases, one-hot
  typedef enum logic [5:0] {
    PH_OPCODE      = 6'b000001,
    PH_COUNT_HI    = 6'b000010,
    PH_COUNT_LO    = 6'b000100,
    PH_ATTR_FIRST  = 6'b001000,
    PH_ATTR_SECOND = 6'b010000,
    PH_HALTED      = 6'b100000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  attr_id;
    logic [15:0] attr_value;
    logic [15:0] vertex_number;
    logic [15:0] tri_first;
    logic [15:0] tri_second;
    logic [15:0] tri_third;
    logic        prim_kind;
    logic        last_of_run;
  } res_t;

  // first enabled slot at or above a start slot, SLOT_END if none
  function automatic logic [3:0] first_slot(input logic [NUM_SLOTS-1:0] en,
                                            input logic [3:0] from);
    logic [3:0] r;
    r = SLOT_END;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (en[i] && (4'(i) >= from)) r = 4'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dlpa_if.sv -----
// dlpa_if: valid/ready channel interfaces of the display-list primitive assembler
// depends on dlpa_pkg for widths
`default_nettype none

// byte stream channel
interface dlpa_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// result channel
interface dlpa_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  attr_id;
  logic [15:0] attr_value;
  logic [15:0] vertex_number;
  logic [15:0] tri_first;
  logic [15:0] tri_second;
  logic [15:0] tri_third;
  logic        prim_kind;
  logic        last_of_run;
  modport source (output valid, output kind, output attr_id, output attr_value,
                  output vertex_number, output tri_first, output tri_second,
                  output tri_third, output prim_kind, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input attr_id, input attr_value,
                input vertex_number, input tri_first, input tri_second,
                input tri_third, input prim_kind, input last_of_run,
                output ready);
endinterface

// configuration write channel
interface dlpa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dlpa_pkg::CFG_IDX_W-1:0] index;
  logic [dlpa_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/display_list_primitive_assembler.sv -----
// Display-list primitive assembler: one stream byte per cycle in, attribute, batch,
// triangle and stop results out; a byte's results are queued as it is taken. Bytes
// are taken every cycle while the result queue has at least two free entries; output
// drains one result per cycle while result.ready is high, so a byte completing an
// attribute and a triangle gives two results. Synchronous reset clears stream state to
// await an opcode, restores register defaults (conversion on) and empties the queue.
`default_nettype none

module display_list_primitive_assembler #(
  parameter int TEXCOORD_SLOTS = dlpa_pkg::TEXCOORD_SLOTS_DEF,
  parameter int QUEUE_DEPTH    = dlpa_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  dlpa_byte_if.sink   stream,
  dlpa_res_if.source  result,
  dlpa_cfg_if.sink    cfg
);
  import dlpa_pkg::*;

  res_t       res0, res1, head;
  logic [1:0] nres;
  logic       room, head_valid, take;

  assign cfg.ready    = 1'b1;
  assign stream.ready = room;
  assign take         = stream.valid && room;

  dlpa_decode #(
    .TEXCOORD_SLOTS(TEXCOORD_SLOTS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .take      (take),
    .data_byte (stream.data_byte),
    .res0      (res0),
    .res1      (res1),
    .nres      (nres)
  );

  dlpa_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .npush      (take ? nres : 2'd0),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (result.ready)
  );

  // result channel
  assign result.valid         = head_valid;
  assign result.kind          = head.kind;
  assign result.attr_id       = head.attr_id;
  assign result.attr_value    = head.attr_value;
  assign result.vertex_number = head.vertex_number;
  assign result.tri_first     = head.tri_first;
  assign result.tri_second    = head.tri_second;
  assign result.tri_third     = head.tri_third;
  assign result.prim_kind     = head.prim_kind;
  assign result.last_of_run   = head.last_of_run;

endmodule

`default_nettype wire

// ----- rtl/dlpa_decode.sv -----
// dlpa_decode: configuration registers, stream state and per-byte result logic
// depends on dlpa_pkg
`default_nettype none

module dlpa_decode #(
  parameter int TEXCOORD_SLOTS = dlpa_pkg::TEXCOORD_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dlpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dlpa_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                           take,
  input  wire logic [7:0]                     data_byte,
  output dlpa_pkg::res_t                      res0,
  output dlpa_pkg::res_t                      res1,
  output logic [1:0]                          nres
);
  import dlpa_pkg::*;

  // configuration registers
  logic       has_matrix_index;
  logic       has_tex_matrix_index;
  logic       has_color;
  logic [7:0] texcoord_enable;
  logic       convert_to_triangles;

  // stream state
  phase_t      phase, phase_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [3:0]  attr_pointer, attr_pointer_next;
  logic [15:0] vertices_left, vertices_left_next;
  logic [15:0] vertex_ordinal, vertex_ordinal_next;
  logic [1:0]  ord_mod3, ord_mod3_next;
  logic        strip_mode, strip_mode_next;

  logic [NUM_SLOTS-1:0] slot_en;
  logic [7:0]           tex_mask;
  logic [3:0]           s_first, fin_slot, nx_slot;
  logic [15:0]          cnt, left_dec;
  logic                 attr_out, tri_out;
  res_t                 attr_res, tri_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      has_matrix_index     <= 1'b0;
      has_tex_matrix_index <= 1'b0;
      has_color            <= 1'b0;
      texcoord_enable      <= 8'd0;
      convert_to_triangles <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HAS_MATRIX:     has_matrix_index     <= cfg_data[0];
        CFG_HAS_TEX_MATRIX: has_tex_matrix_index <= cfg_data[0];
        CFG_HAS_COLOR:      has_color            <= cfg_data[0];
        CFG_TEXCOORD_EN:    texcoord_enable      <= cfg_data;
        CFG_CONVERT:        convert_to_triangles <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // enabled attribute slots
  always_comb begin
    for (int i = 0; i < TEXCOORD_MAX; i++) begin
      tex_mask[i] = texcoord_enable[i] && (i < TEXCOORD_SLOTS);
    end
    slot_en = '0;
    slot_en[SLOT_MATRIX]   = has_matrix_index;
    slot_en[SLOT_TEXMTX]   = has_tex_matrix_index;
    slot_en[SLOT_POSITION] = 1'b1;
    slot_en[SLOT_NORMAL]   = 1'b1;
    slot_en[SLOT_COLOR]    = has_color;
    slot_en[SLOT_PAD-1:SLOT_TEX0] = tex_mask;
    slot_en[SLOT_PAD]      = ~|tex_mask;
  end

  // slot lookups for the current byte and the one after it
  always_comb begin
    s_first = first_slot(slot_en, attr_pointer);
    if (s_first == SLOT_END) s_first = SLOT_PAD;
    fin_slot = (phase == PH_ATTR_FIRST) ? s_first : attr_pointer;
    nx_slot  = first_slot(slot_en, fin_slot + 4'd1);
    cnt      = {high_byte_hold, data_byte};
    left_dec = vertices_left - 16'd1;
  end

  // attribute and triangle result candidates
  always_comb begin
    attr_res               = '0;
    attr_res.kind          = KIND_ATTR;
    attr_res.attr_id       = fin_slot;
    attr_res.attr_value    = (phase == PH_ATTR_FIRST) ? {8'd0, data_byte} : cnt;
    attr_res.vertex_number = vertex_ordinal;
    attr_res.prim_kind     = strip_mode;

    tri_res               = '0;
    tri_res.kind          = KIND_TRI;
    tri_res.vertex_number = vertex_ordinal;
    tri_res.prim_kind     = strip_mode;
    tri_res.tri_third     = vertex_ordinal;
    if (strip_mode && vertex_ordinal[0]) begin
      // odd strip triangle keeps the winding by swapping the first two
      tri_res.tri_first  = vertex_ordinal - 16'd1;
      tri_res.tri_second = vertex_ordinal - 16'd2;
    end else begin
      tri_res.tri_first  = vertex_ordinal - 16'd2;
      tri_res.tri_second = vertex_ordinal - 16'd1;
    end
  end

  // next state and result selection
  always_comb begin
    phase_next          = phase;
    high_byte_hold_next = high_byte_hold;
    attr_pointer_next   = attr_pointer;
    vertices_left_next  = vertices_left;
    vertex_ordinal_next = vertex_ordinal;
    ord_mod3_next       = ord_mod3;
    strip_mode_next     = strip_mode;
    attr_out            = 1'b0;
    tri_out             = 1'b0;
    res0                = '0;
    res1                = '0;
    nres                = 2'd0;

    case (phase)
      PH_OPCODE: begin
        if (data_byte == OP_STRIP || data_byte == OP_LIST) begin
          strip_mode_next = (data_byte == OP_STRIP);
          phase_next      = PH_COUNT_HI;
        end else begin
          res0.kind      = KIND_STOPPED;
          res0.prim_kind = strip_mode;
          nres           = 2'd1;
          phase_next     = PH_HALTED;
        end
      end
      PH_COUNT_HI: begin
        high_byte_hold_next = data_byte;
        phase_next          = PH_COUNT_LO;
      end
      PH_COUNT_LO: begin
        res0.prim_kind = strip_mode;
        nres           = 2'd1;
        if (cnt == 16'd0) begin
          res0.kind  = KIND_STOPPED;
          phase_next = PH_HALTED;
        end else begin
          res0.kind           = KIND_BATCH;
          res0.attr_value     = cnt;
          vertices_left_next  = cnt;
          vertex_ordinal_next = 16'd0;
          ord_mod3_next       = 2'd0;
          attr_pointer_next   = 4'd0;
          phase_next          = PH_ATTR_FIRST;
        end
      end
      PH_ATTR_FIRST, PH_ATTR_SECOND: begin
        if (phase == PH_ATTR_FIRST && fin_slot > SLOT_TEXMTX) begin
          // first byte of a 16-bit attribute
          attr_pointer_next   = fin_slot;
          high_byte_hold_next = data_byte;
          phase_next          = PH_ATTR_SECOND;
        end else begin
          attr_out = (fin_slot != SLOT_PAD);
          if (nx_slot != SLOT_END) begin
            attr_pointer_next = nx_slot;
            phase_next        = PH_ATTR_FIRST;
          end else begin
            // vertex complete
            if (convert_to_triangles) begin
              if (strip_mode) tri_out = (vertex_ordinal[15:1] != 15'd0);
              else            tri_out = (ord_mod3 == 2'd2);
            end
            vertex_ordinal_next = vertex_ordinal + 16'd1;
            ord_mod3_next       = (ord_mod3 == 2'd2) ? 2'd0 : ord_mod3 + 2'd1;
            vertices_left_next  = left_dec;
            attr_pointer_next   = 4'd0;
            phase_next          = (left_dec != 16'd0) ? PH_ATTR_FIRST : PH_OPCODE;
          end
          if (attr_out) begin
            res0 = attr_res;
            res1 = tri_res;
          end else begin
            res0 = tri_res;
          end
          nres = {1'b0, attr_out} + {1'b0, tri_out};
        end
      end
      PH_HALTED: ;
      default: phase_next = PH_OPCODE;
    endcase

    // mark the final result of this byte
    if (nres == 2'd2) res1.last_of_run = 1'b1;
    else if (nres == 2'd1) res0.last_of_run = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_OPCODE;
      high_byte_hold <= 8'd0;
      attr_pointer   <= 4'd0;
      vertices_left  <= 16'd0;
      vertex_ordinal <= 16'd0;
      ord_mod3       <= 2'd0;
      strip_mode     <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      high_byte_hold <= high_byte_hold_next;
      attr_pointer   <= attr_pointer_next;
      vertices_left  <= vertices_left_next;
      vertex_ordinal <= vertex_ordinal_next;
      ord_mod3       <= ord_mod3_next;
      strip_mode     <= strip_mode_next;
    end
  end

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALTED) |-> (nres == 2'd0))
    else $error("halted decoder produced a result");
  a_attr_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ATTR_FIRST || phase == PH_ATTR_SECOND) |-> (vertices_left != 16'd0))
    else $error("vertex phase with no vertices left");
  a_second_is_tri: assert property (@(posedge clk) disable iff (rst)
    (nres == 2'd2) |-> (res0.kind == KIND_ATTR && res1.kind == KIND_TRI))
    else $error("two results that are not attribute then triangle");
  a_mod3_track: assert property (@(posedge clk) disable iff (rst)
    take && (phase == PH_COUNT_LO) && (cnt != 16'd0) |=> (ord_mod3 == 2'd0))
    else $error("ordinal residue not cleared at batch start");
`endif

endmodule

`default_nettype wire

// ----- rtl/dlpa_queue.sv -----
// dlpa_queue: small result queue, up to two pushes and one pop per cycle
// depends on dlpa_pkg for the result type
`default_nettype none

module dlpa_queue #(
  parameter int DEPTH = dlpa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dlpa_pkg::res_t push0,
  input  wire dlpa_pkg::res_t push1,
  input  wire logic [1:0]     npush,
  output logic                room,
  output logic                head_valid,
  output dlpa_pkg::res_t      head,
  input  wire logic           pop
);
  import dlpa_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM2 = CW'(DEPTH - 2);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CW-1:0] count;
  logic          do_pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  assign wr_ptr1    = wrap_inc(wr_ptr);
  assign room       = (count <= ROOM2);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  // storage writes
  always_ff @(posedge clk) begin
    if (npush != 2'd0) mem[wr_ptr] <= push0;
    if (npush == 2'd2) mem[wr_ptr1] <= push1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (npush)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= wrap_inc(wr_ptr1);
        default: ;
      endcase
      if (do_pop) rd_ptr <= wrap_inc(rd_ptr);
      count <= count + CW'(npush) - CW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (npush != 2'd0) |-> (count <= ROOM2))
    else $error("result queue push without room");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count out of range");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(1)) && do_pop && (npush == 2'd0) |=> !head_valid)
    else $error("result queue not empty after last pop");
`endif

endmodule

`default_nettype wire
